/* src/rational_sub_div_reduce_core_macros.svh */
// assertion macros for the rational subtract / divide core
// used by rational_sub_div_reduce_core, no other dependencies
`ifndef RATIONAL_SUB_DIV_REDUCE_CORE_MACROS_SVH
`define RATIONAL_SUB_DIV_REDUCE_CORE_MACROS_SVH

// clocked assertion, disabled while the active-low reset is low
`define RSDR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rsdr assertion failed");

// implication shorthand under the same clock and reset
`define RSDR_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    `RSDR_ASSERT(label, clk, rst_n, (cond) |-> (prop))

`endif

/* src/rsdr_pkg.sv */
// shared constants, codes and helpers for the rational subtract / divide core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rsdr_pkg;

    // field width and operand width
    localparam int FIELD_W    = 32;
    localparam int WORD_WIDTH = 32;
    localparam int PROD_W     = 2 * FIELD_W;
    localparam int CNT_W      = $clog2(PROD_W);

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // operation select
    localparam logic ACT_SUB = 1'b0;
    localparam logic ACT_DIV = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL0 = 9'b000000010,
        S_MUL1 = 9'b000000100,
        S_MUL2 = 9'b000001000,
        S_MUL3 = 9'b000010000,
        S_DIFF = 9'b000100000,
        S_GCD  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_state;

    // compare / subtract unit result
    typedef struct packed {
        logic [PROD_W:0] diff;
        logic            ge;
    } t_sub_res;

    // low WORD_WIDTH bits read as two's complement
    function automatic logic signed [FIELD_W-1:0] sext_word(input logic [FIELD_W-1:0] x);
        logic [FIELD_W-1:0] s;
        s = x << (FIELD_W - WORD_WIDTH);
        return $signed(s) >>> (FIELD_W - WORD_WIDTH);
    endfunction

    // signed product to order-preserving offset binary
    function automatic logic [PROD_W:0] to_offset(input logic [PROD_W-1:0] x);
        return {~x[PROD_W-1], x};
    endfunction

endpackage

`default_nettype wire

/* src/rsdr_mul.sv */
// shared signed multiplier with registered product
// depends on rsdr_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsdr_mul (
    input  wire logic                              i_clk,
    input  wire logic signed [rsdr_pkg::FIELD_W-1:0] i_a,
    input  wire logic signed [rsdr_pkg::FIELD_W-1:0] i_b,
    output logic signed [rsdr_pkg::PROD_W-1:0]   o_prod
);

    logic signed [rsdr_pkg::PROD_W-1:0] r_prod;
    logic signed [rsdr_pkg::PROD_W-1:0] n_prod;

    // full-width signed product
    always_comb begin
        n_prod = rsdr_pkg::PROD_W'(i_a) * rsdr_pkg::PROD_W'(i_b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* src/rsdr_sub.sv */
// shared wide compare and subtract unit
// depends on rsdr_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsdr_sub (
    input  wire logic [rsdr_pkg::PROD_W:0] i_a,
    input  wire logic [rsdr_pkg::PROD_W:0] i_b,
    output rsdr_pkg::t_sub_res            o_res
);

    logic [rsdr_pkg::PROD_W+1:0] w_full;

    // borrow of the extended difference gives the compare
    always_comb begin
        w_full     = {1'b0, i_a} - {1'b0, i_b};
        o_res.diff = w_full[rsdr_pkg::PROD_W:0];
        o_res.ge   = ~w_full[rsdr_pkg::PROD_W+1];
    end

endmodule

`default_nettype wire

/* src/rational_sub_div_reduce_core.sv */
// rational subtract / divide core: sequencer, operand and result registers
// depends on rsdr_pkg, rsdr_mul, rsdr_sub and the macros header
//
// channel  dir  tdata (low bit up)                         tuser
// s_axis   in   a_num[31:0] a_den[31:0] b_num[31:0] b_den  action
// m_axis   out  res_num[31:0] res_den[30:0] zero pad       status
//
// an error input goes straight to the result; an ordinary one runs the products and
// difference, then the binary gcd, then 128 division steps (64 per part on the
// shared subtract unit).
// each gcd step swaps, subtracts or halves the two magnitudes.
// s_axis_tready is high only while the sequencer is idle.
// a finished result waits in the output register; the next item may start.
// i_rst_n is synchronous and clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_sub_div_reduce_core_macros.svh"

module rational_sub_div_reduce_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  wire logic [0:0]   s_axis_tuser,  // action
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata,  // res_num, res_den, one zero bit
    output logic [1:0]        m_axis_tuser   // status
);

    localparam int FW = rsdr_pkg::FIELD_W;
    localparam int PW = rsdr_pkg::PROD_W;
    localparam int CW = rsdr_pkg::CNT_W;

    rsdr_pkg::t_state r_state, n_state;

    logic                 r_act, n_act;
    logic signed [FW-1:0] r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic [1:0]           r_status, n_status;
    logic [PW-1:0]        r_p, n_p, r_q, n_q;
    logic [PW-1:0]        r_nmag, n_nmag, r_dmag, n_dmag;
    logic                 r_dneg, n_dneg, r_neg, n_neg, r_swap, n_swap;
    logic [PW-1:0]        r_u, n_u, r_v, n_v, r_g, n_g;
    logic [CW-1:0]        r_k, n_k, r_cnt, n_cnt;
    logic [PW-1:0]        r_rem, n_rem, r_quo, n_quo;
    logic                 r_phase, n_phase;
    logic                 r_ovalid, n_ovalid;
    logic [FW-1:0]        r_onum, n_onum;
    logic [FW-2:0]        r_oden, n_oden;
    logic [1:0]           r_ost, n_ost;

    logic signed [FW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_prod;
    logic [PW:0]          w_sa, w_sb;
    rsdr_pkg::t_sub_res   w_sub;

    logic signed [FW-1:0] w_in_an, w_in_ad, w_in_bn, w_in_bd;
    logic [PW-1:0]        w_nm, w_lim, w_quo_nx;
    logic                 w_nneg, w_ovf;

    rsdr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    rsdr_sub u_sub (
        .i_a   (w_sa),
        .i_b   (w_sb),
        .o_res (w_sub)
    );

    // input operands reduced to the word width
    always_comb begin
        w_in_an = rsdr_pkg::sext_word(s_axis_tdata[31:0]);
        w_in_ad = rsdr_pkg::sext_word(s_axis_tdata[63:32]);
        w_in_bn = rsdr_pkg::sext_word(s_axis_tdata[95:64]);
        w_in_bd = rsdr_pkg::sext_word(s_axis_tdata[127:96]);
    end

    // multiplier operand select
    always_comb begin
        case (r_state)
            rsdr_pkg::S_MUL0: begin w_ma = r_an; w_mb = r_bd; end
            rsdr_pkg::S_MUL1: begin w_ma = r_bn; w_mb = r_ad; end
            rsdr_pkg::S_MUL2: begin
                w_ma = r_ad;
                w_mb = (r_act == rsdr_pkg::ACT_DIV) ? r_bn : r_bd;
            end
            default: begin w_ma = r_an; w_mb = r_bd; end
        endcase
    end

    // subtract unit operand select
    always_comb begin
        case (r_state)
            rsdr_pkg::S_DIFF: begin
                w_sa = r_swap ? rsdr_pkg::to_offset(r_q) : rsdr_pkg::to_offset(r_p);
                w_sb = r_swap ? rsdr_pkg::to_offset(r_p) : rsdr_pkg::to_offset(r_q);
            end
            rsdr_pkg::S_GCD: begin w_sa = {1'b0, r_u}; w_sb = {1'b0, r_v}; end
            rsdr_pkg::S_DIV: begin w_sa = {r_rem, r_quo[PW-1]}; w_sb = {1'b0, r_g}; end
            default: begin w_sa = '0; w_sb = '0; end
        endcase
    end

    // helpers for difference, division and range check
    always_comb begin
        w_quo_nx = {r_quo[PW-2:0], w_sub.ge};
        w_lim    = PW'(1) << (rsdr_pkg::WORD_WIDTH - 1);
        w_ovf    = (r_dmag > w_lim - PW'(1)) ||
                   (r_neg ? (r_nmag > w_lim) : (r_nmag > w_lim - PW'(1)));
        if (r_act == rsdr_pkg::ACT_DIV) begin
            w_nm   = r_p[PW-1] ? PW'(-r_p) : r_p;
            w_nneg = r_p[PW-1];
        end else begin
            w_nm   = w_sub.diff[PW-1:0];
            w_nneg = r_swap;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;  n_act = r_act;
        n_an = r_an;  n_ad = r_ad;  n_bn = r_bn;  n_bd = r_bd;
        n_status = r_status;  n_p = r_p;  n_q = r_q;
        n_nmag = r_nmag;  n_dmag = r_dmag;  n_dneg = r_dneg;
        n_neg = r_neg;  n_swap = r_swap;
        n_u = r_u;  n_v = r_v;  n_g = r_g;  n_k = r_k;
        n_cnt = r_cnt;  n_rem = r_rem;  n_quo = r_quo;  n_phase = r_phase;
        n_ovalid = r_ovalid;  n_onum = r_onum;  n_oden = r_oden;  n_ost = r_ost;

        // output transfer frees the result register
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            rsdr_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_act = s_axis_tuser[0];
                    n_an = w_in_an;  n_ad = w_in_ad;
                    n_bn = w_in_bn;  n_bd = w_in_bd;
                    n_swap = 1'b0;
                    if (w_in_ad == '0 || w_in_bd == '0) begin
                        n_status = rsdr_pkg::ST_ZERO_DEN;
                        n_state  = rsdr_pkg::S_FIN;
                    end else if (s_axis_tuser[0] == rsdr_pkg::ACT_DIV && w_in_bn == '0) begin
                        n_status = rsdr_pkg::ST_DIV_ZERO;
                        n_state  = rsdr_pkg::S_FIN;
                    end else begin
                        n_status = rsdr_pkg::ST_OK;
                        n_state  = rsdr_pkg::S_MUL0;
                    end
                end
            end
            rsdr_pkg::S_MUL0: n_state = rsdr_pkg::S_MUL1;
            rsdr_pkg::S_MUL1: begin
                n_p = w_prod;
                n_state = rsdr_pkg::S_MUL2;
            end
            rsdr_pkg::S_MUL2: begin
                n_q = w_prod;
                n_state = rsdr_pkg::S_MUL3;
            end
            rsdr_pkg::S_MUL3: begin
                n_dneg = w_prod[PW-1];
                n_dmag = w_prod[PW-1] ? PW'(-w_prod) : w_prod;
                n_state = rsdr_pkg::S_DIFF;
            end
            rsdr_pkg::S_DIFF: begin
                if (r_act == rsdr_pkg::ACT_SUB && !r_swap && !w_sub.ge) begin
                    // p below q: take q - p next cycle
                    n_swap = 1'b1;
                end else if (w_nm == '0) begin
                    // zero result is 0/1
                    n_nmag = '0;
                    n_dmag = PW'(1);
                    n_neg  = 1'b0;
                    n_state = rsdr_pkg::S_FIN;
                end else begin
                    n_nmag = w_nm;
                    n_neg  = w_nneg ^ r_dneg;
                    n_u = w_nm;
                    n_v = r_dmag;
                    n_k = '0;
                    n_state = rsdr_pkg::S_GCD;
                end
            end
            rsdr_pkg::S_GCD: begin
                // binary gcd, one step a cycle
                if (r_u == '0 || r_v == '0) begin
                    n_g = (r_u | r_v) << r_k;
                    n_quo = r_nmag;
                    n_rem = '0;
                    n_cnt = '0;
                    n_phase = 1'b0;
                    n_state = rsdr_pkg::S_DIV;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + CW'(1);
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (w_sub.ge) begin
                    n_u = w_sub.diff[PW-1:0];
                end else begin
                    n_u = r_v;
                    n_v = r_u;
                end
            end
            rsdr_pkg::S_DIV: begin
                // restoring division by the gcd, one quotient bit a cycle
                n_quo = w_quo_nx;
                n_rem = w_sub.ge ? w_sub.diff[PW-1:0] : w_sa[PW-1:0];
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(PW - 1)) begin
                    n_cnt = '0;
                    n_rem = '0;
                    if (!r_phase) begin
                        n_nmag = w_quo_nx;
                        n_quo = r_dmag;
                        n_phase = 1'b1;
                    end else begin
                        n_dmag = w_quo_nx;
                        n_state = rsdr_pkg::S_FIN;
                    end
                end
            end
            rsdr_pkg::S_FIN: begin
                // load the result once the output register is free
                if (!n_ovalid) begin
                    n_ovalid = 1'b1;
                    n_state = rsdr_pkg::S_IDLE;
                    if (r_status != rsdr_pkg::ST_OK) begin
                        n_onum = '0;  n_oden = '0;  n_ost = r_status;
                    end else if (w_ovf) begin
                        n_onum = '0;  n_oden = '0;  n_ost = rsdr_pkg::ST_OVERFLOW;
                    end else begin
                        n_onum = r_neg ? FW'(-r_nmag) : r_nmag[FW-1:0];
                        n_oden = r_dmag[FW-2:0];
                        n_ost  = rsdr_pkg::ST_OK;
                    end
                end
            end
            default: n_state = rsdr_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rsdr_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_act <= n_act;  r_an <= n_an;  r_ad <= n_ad;  r_bn <= n_bn;  r_bd <= n_bd;
        r_status <= n_status;  r_p <= n_p;  r_q <= n_q;
        r_nmag <= n_nmag;  r_dmag <= n_dmag;  r_dneg <= n_dneg;
        r_neg <= n_neg;  r_swap <= n_swap;
        r_u <= n_u;  r_v <= n_v;  r_g <= n_g;  r_k <= n_k;
        r_cnt <= n_cnt;  r_rem <= n_rem;  r_quo <= n_quo;  r_phase <= n_phase;
        r_onum <= n_onum;  r_oden <= n_oden;  r_ost <= n_ost;
    end

    assign s_axis_tready = (r_state == rsdr_pkg::S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_oden, r_onum};
    assign m_axis_tuser  = r_ost;

    // checks
    `RSDR_ASSERT(a_state_onehot, i_clk, i_rst_n, $onehot(r_state))
    `RSDR_ASSERT_IMP(a_ok_den_pos, i_clk, i_rst_n,
        r_ovalid && r_ost == rsdr_pkg::ST_OK, r_oden != '0)
    `RSDR_ASSERT_IMP(a_err_zero, i_clk, i_rst_n,
        r_ovalid && r_ost != rsdr_pkg::ST_OK, r_onum == '0 && r_oden == '0)
    `RSDR_ASSERT_IMP(a_div_gcd_nz, i_clk, i_rst_n,
        r_state == rsdr_pkg::S_DIV, r_g != '0)

endmodule

`default_nettype wire
